FILE: design/rqu8_pkg.sv
// ----------------------------------------------------------------------------
// rqu8_pkg
// Shared types and constants for the accumulator-to-byte requantizer.
// ----------------------------------------------------------------------------
package rqu8_pkg;

  // Default accumulator width taken from the accumulator input.
  localparam int unsigned ACC_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Pipeline depth from the accept edge to the output register.
  localparam int unsigned PIPE_DEPTH = 6;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_POINT        = 3'd0,
    CFG_PER_COLUMN_SCALE  = 3'd1,
    CFG_TENSOR_SCALE_MULT = 3'd2,
    CFG_SCALE_SHIFT       = 3'd3,
    CFG_ADD_BIAS          = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [7:0]  ZERO_POINT_RST        = 8'd0;
  localparam logic        PER_COLUMN_SCALE_RST  = 1'b0;
  localparam logic [31:0] TENSOR_SCALE_MULT_RST = 32'h8000_0000;
  localparam logic [5:0]  SCALE_SHIFT_RST       = 6'd31;
  localparam logic        ADD_BIAS_RST          = 1'b1;

endpackage

FILE: design/requantize_accumulator_to_uint8.sv
// ----------------------------------------------------------------------------
// requantize_accumulator_to_uint8
// Requantizes a signed matrix accumulator (plus optional column bias) to an
// unsigned byte through a fixed-point scale, round-half-even and clamp.
// ----------------------------------------------------------------------------
// Pipeline: six register stages, one per pipeline step; a request taken at a
//   clock edge passes through stages 1 to 6 in order before it shows on valid_o.
// Throughput: one request per cycle; busy_o stays low, and the receiver cannot
//   stall, so every stage advances on every clock.
// Reset: rst_ni clears all stage valid bits and loads the configuration
//   registers with their reset values (unity scale, bias added, zero point 0).
// ----------------------------------------------------------------------------
module requantize_accumulator_to_uint8 #(
  parameter int unsigned ACC_BITS = rqu8_pkg::ACC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [rqu8_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rqu8_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Request side
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [31:0]               accumulator_i,
  input  logic signed [31:0]               column_bias_i,
  input  logic [31:0]                      column_scale_mult_i,
  input  logic                             end_of_tensor_i,
  // Result side
  output logic                             valid_o,
  output logic [7:0]                       quantized_value_o,
  output logic                             last_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  zero_point_q;
  logic        per_column_scale_q;
  logic [31:0] tensor_scale_mult_q;
  logic [5:0]  scale_shift_q;
  logic        add_bias_q;

  // Drop writes to indexes beyond the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_point_q        <= rqu8_pkg::ZERO_POINT_RST;
      per_column_scale_q  <= rqu8_pkg::PER_COLUMN_SCALE_RST;
      tensor_scale_mult_q <= rqu8_pkg::TENSOR_SCALE_MULT_RST;
      scale_shift_q       <= rqu8_pkg::SCALE_SHIFT_RST;
      add_bias_q          <= rqu8_pkg::ADD_BIAS_RST;
    end else if (cfg_we_i) begin
      case (rqu8_pkg::cfg_idx_e'(cfg_idx_i))
        rqu8_pkg::CFG_ZERO_POINT:        zero_point_q        <= cfg_wdata_i[7:0];
        rqu8_pkg::CFG_PER_COLUMN_SCALE:  per_column_scale_q  <= cfg_wdata_i[0];
        rqu8_pkg::CFG_TENSOR_SCALE_MULT: tensor_scale_mult_q <= cfg_wdata_i[31:0];
        rqu8_pkg::CFG_SCALE_SHIFT:       scale_shift_q       <= cfg_wdata_i[5:0];
        rqu8_pkg::CFG_ADD_BIAS:          add_bias_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds off a request.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // --------------------------------------------------------------------------
  // Valid bits, one per stage; clear on reset, advance every clock.
  // --------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sign-extend the accumulator's low ACC_BITS bits and add the bias.
  // The 33-bit sum never wraps. Also pick the scale multiplier.
  // --------------------------------------------------------------------------
  logic signed [32:0] acc_ext;
  logic signed [32:0] bias_ext;
  logic signed [32:0] s1_sum_d, s1_sum_q;
  logic [31:0]        s1_mult_d, s1_mult_q;
  logic               s1_last_q;

  assign acc_ext  = {{(33 - ACC_BITS){accumulator_i[ACC_BITS-1]}},
                     accumulator_i[ACC_BITS-1:0]};
  assign bias_ext = add_bias_q ? {column_bias_i[31], column_bias_i} : 33'sd0;
  assign s1_sum_d  = acc_ext + bias_ext;
  assign s1_mult_d = per_column_scale_q ? column_scale_mult_i : tensor_scale_mult_q;

  always_ff @(posedge clk_i) begin
    s1_sum_q  <= s1_sum_d;
    s1_mult_q <= s1_mult_d;
    s1_last_q <= end_of_tensor_i;
  end

  // --------------------------------------------------------------------------
  // Stage 2: split into sign and magnitude; rounding is symmetric, so work on
  // the magnitude from here on.
  // --------------------------------------------------------------------------
  logic        s2_neg_q;
  logic [32:0] s2_mag_d, s2_mag_q;
  logic [31:0] s2_mult_q;
  logic        s2_last_q;

  assign s2_mag_d = s1_sum_q[32] ? (~s1_sum_q + 33'd1) : s1_sum_q;

  always_ff @(posedge clk_i) begin
    s2_neg_q  <= s1_sum_q[32];
    s2_mag_q  <= s2_mag_d;
    s2_mult_q <= s1_mult_q;
    s2_last_q <= s1_last_q;
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitude times multiplier. The magnitude reaches bit 32 only for
  // exactly 2^32, where its low bits are zero, so one 32x32 multiplier serves.
  // --------------------------------------------------------------------------
  logic [63:0] s3_prod_d, s3_prod_q;
  logic        s3_neg_q;
  logic        s3_last_q;

  assign s3_prod_d = s2_mag_q[32] ? {s2_mult_q, 32'd0}
                                  : (64'(s2_mag_q[31:0]) * 64'(s2_mult_q));

  always_ff @(posedge clk_i) begin
    s3_prod_q <= s3_prod_d;
    s3_neg_q  <= s2_neg_q;
    s3_last_q <= s2_last_q;
  end

  // --------------------------------------------------------------------------
  // Stage 4: shift right and decide the round-half-even increment.
  // A zero shift passes the product unrounded.
  // --------------------------------------------------------------------------
  logic [63:0] rnd_mask;
  logic [63:0] rnd_half;
  logic [63:0] rnd_rem;
  logic [63:0] s4_quo_d, s4_quo_q;
  logic        s4_up_d, s4_up_q;
  logic        s4_neg_q;
  logic        s4_last_q;

  assign rnd_mask = (64'd1 << scale_shift_q) - 64'd1;
  assign rnd_half = (scale_shift_q == 6'd0) ? 64'd0 : (64'd1 << (scale_shift_q - 6'd1));
  assign rnd_rem  = s3_prod_q & rnd_mask;
  assign s4_quo_d = s3_prod_q >> scale_shift_q;
  assign s4_up_d  = (scale_shift_q != 6'd0) &&
                    ((rnd_rem > rnd_half) || ((rnd_rem == rnd_half) && s4_quo_d[0]));

  always_ff @(posedge clk_i) begin
    s4_quo_q  <= s4_quo_d;
    s4_up_q   <= s4_up_d;
    s4_neg_q  <= s3_neg_q;
    s4_last_q <= s3_last_q;
  end

  // --------------------------------------------------------------------------
  // Stage 5: apply the increment and saturate to nine bits. A nonzero shift
  // leaves headroom for the increment; a zero shift never increments.
  // --------------------------------------------------------------------------
  logic [63:0] rnd_quo;
  logic [8:0]  s5_sat_d, s5_sat_q;
  logic        s5_neg_q;
  logic        s5_last_q;

  assign rnd_quo  = s4_quo_q + 64'(s4_up_q);
  assign s5_sat_d = (|rnd_quo[63:8]) ? 9'd256 : {1'b0, rnd_quo[7:0]};

  always_ff @(posedge clk_i) begin
    s5_sat_q  <= s5_sat_d;
    s5_neg_q  <= s4_neg_q;
    s5_last_q <= s4_last_q;
  end

  // --------------------------------------------------------------------------
  // Stage 6: clamp against the zero point and offset; this is the output
  // register.
  // --------------------------------------------------------------------------
  logic [8:0] zp_ext;
  logic [8:0] room;
  logic [7:0] s6_res_d, s6_res_q;
  logic       s6_last_q;

  assign zp_ext = {1'b0, zero_point_q};
  assign room   = {1'b0, rqu8_pkg::BYTE_MAX} - zp_ext;

  always_comb begin
    if (s5_neg_q) begin
      s6_res_d = (s5_sat_q > zp_ext) ? 8'd0 : 8'(zp_ext - s5_sat_q);
    end else begin
      s6_res_d = (s5_sat_q > room) ? rqu8_pkg::BYTE_MAX : 8'(zp_ext + s5_sat_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s6_res_q  <= s6_res_d;
    s6_last_q <= s5_last_q;
  end

  assign valid_o           = s6_vld_q;
  assign quantized_value_o = s6_res_q;
  assign last_o            = s6_last_q;

endmodule

FILE: design/rqu8_checker.sv
// ----------------------------------------------------------------------------
// rqu8_checker
// Port-level timing checks for the requantizer, bound to the top level.
// ----------------------------------------------------------------------------
module rqu8_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic end_of_tensor_i,
  input logic valid_o,
  input logic last_o
);

  // Every taken request yields a result once it has passed through the pipeline.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 valid_o)
    else $error("request taken but no result after pipeline depth");

  // No result appears without a matching request taken at the pipeline's input.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##6 !valid_o)
    else $error("result strobe without matching request");

  // The last flag travels with its element.
  a_last_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 (last_o == $past(end_of_tensor_i, 6)))
    else $error("last flag does not match its request");

endmodule

bind requantize_accumulator_to_uint8 rqu8_checker u_rqu8_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .end_of_tensor_i (end_of_tensor_i),
  .valid_o         (valid_o),
  .last_o          (last_o)
);
